// ===== sv/qfs_pkg.sv =====
`timescale 1ns / 1ps

package qfs_pkg;

  // alphabet and table geometry
  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned TABLE_ENTRIES = 456976;
  localparam int unsigned SQ_SIZE       = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int unsigned CUBE_SIZE     = SQ_SIZE * ALPHABET_SIZE;

  // field widths
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned INDEX_W  = 19;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned ACC_W    = 32;

  // internal widths
  localparam int unsigned SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int unsigned WIN_W  = $clog2(CUBE_SIZE * ALPHABET_SIZE);
  localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);

  // stream packing
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // tuser code for the input item kind
  localparam logic MODE_TEXT = 1'b1;

  // floor score after reset, -25.0 in Q7.8
  localparam logic signed [SCORE_W-1:0] FLOOR_RESET = -16'sd6400;

  typedef enum logic {
    REQ_WRITE,
    REQ_LOOKUP
  } req_kind_e;

  // one request handed from front to back
  typedef struct packed {
    req_kind_e                  kind;
    logic [ADDR_W-1:0]          addr;
    logic signed [SCORE_W-1:0]  value;
    logic                       score;
    logic                       last;
    logic                       floor_only;
  } qfs_req_t;

  // one table word: score plus written mark
  typedef struct packed {
    logic signed [SCORE_W-1:0]  score;
    logic                       valid;
  } table_word_t;

endpackage

// ===== sv/qfs_front.sv =====
`timescale 1ns / 1ps

module qfs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [qfs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  logic                           busy_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output qfs_pkg::qfs_req_t              push_req_o
);
  import qfs_pkg::*;

  logic [LETTER_W-1:0]       letter;
  logic [INDEX_W-1:0]        table_index;
  logic signed [SCORE_W-1:0] table_value;
  logic                      is_text;
  logic                      accept;
  logic                      window_full;
  logic [SYM_W-1:0]          sym;
  logic [WIN_W-1:0]          window;
  logic                      window_in_range;
  logic                      index_in_range;

  // last three letters of the current text, oldest first
  logic [SYM_W-1:0] l1_q, l1_d, l2_q, l2_d, l3_q, l3_d;
  logic [1:0]       seen_q, seen_d;

  assign letter      = s_axis_tdata[LETTER_W-1:0];
  assign table_index = s_axis_tdata[LETTER_W+INDEX_W-1:LETTER_W];
  assign table_value = $signed(s_axis_tdata[LETTER_W+INDEX_W+SCORE_W-1:LETTER_W+INDEX_W]);
  assign is_text     = (s_axis_tuser[0] == MODE_TEXT);

  assign s_axis_tready = push_ready_i && !busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign window_full   = (seen_q == 2'd3);

  // clamp letters beyond the alphabet
  always_comb begin
    if (32'(letter) >= ALPHABET_SIZE) begin
      sym = SYM_W'(ALPHABET_SIZE - 1);
    end else begin
      sym = SYM_W'(letter);
    end
  end

  // base-26 window index, first letter most significant
  assign window = WIN_W'(l1_q) * WIN_W'(CUBE_SIZE) + WIN_W'(l2_q) * WIN_W'(SQ_SIZE)
                + WIN_W'(l3_q) * WIN_W'(ALPHABET_SIZE) + WIN_W'(sym);
  assign window_in_range = (32'(window) < TABLE_ENTRIES);
  assign index_in_range  = (32'(table_index) < TABLE_ENTRIES);

  // only table writes in range and letters that score or close a text go on
  always_comb begin
    push_req_o = '0;
    if (is_text) begin
      push_req_o.kind       = REQ_LOOKUP;
      push_req_o.addr       = ADDR_W'(window);
      push_req_o.score      = window_full;
      push_req_o.last       = s_axis_tlast;
      push_req_o.floor_only = !window_in_range;
      push_valid_o          = accept && (window_full || s_axis_tlast);
    end else begin
      push_req_o.kind  = REQ_WRITE;
      push_req_o.addr  = ADDR_W'(table_index);
      push_req_o.value = table_value;
      push_valid_o     = accept && index_in_range;
    end
  end

  always_comb begin
    l1_d   = l1_q;
    l2_d   = l2_q;
    l3_d   = l3_q;
    seen_d = seen_q;
    if (accept && is_text) begin
      if (s_axis_tlast) begin
        l1_d   = '0;
        l2_d   = '0;
        l3_d   = '0;
        seen_d = '0;
      end else begin
        l1_d = l2_q;
        l2_d = l3_q;
        l3_d = sym;
        if (!window_full) begin
          seen_d = seen_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= '0;
      l2_q   <= '0;
      l3_q   <= '0;
      seen_q <= '0;
    end else begin
      l1_q   <= l1_d;
      l2_q   <= l2_d;
      l3_q   <= l3_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== sv/qfs_queue.sv =====
`timescale 1ns / 1ps

module qfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  qfs_pkg::qfs_req_t push_req_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output qfs_pkg::qfs_req_t pop_req_o
);
  import qfs_pkg::*;

  qfs_req_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (32'(count_q) < QUEUE_DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_req_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ===== sv/qfs_back.sv =====
`timescale 1ns / 1ps

module qfs_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  qfs_pkg::qfs_req_t                   pop_req_i,
  input  logic signed [qfs_pkg::SCORE_W-1:0]  floor_score_i,
  output logic                                busy_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic signed [qfs_pkg::ACC_W-1:0]    text_score_o,
  output logic                                saturated_o
);
  import qfs_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // score table with written marks
  table_word_t       mem [TABLE_ENTRIES];
  table_word_t       rdata_q;
  logic [ADDR_W-1:0] mem_addr;
  table_word_t       mem_wdata;
  logic              mem_we, mem_re;

  // clearing sweep after reset
  logic              clearing_q, clearing_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  // lookup stage
  logic b_valid_q, b_valid_d;
  logic b_score_q, b_last_q, b_floor_q;

  // accumulator
  logic signed [ACC_W-1:0]   run_q, run_d;
  logic                      sat_q, sat_d;
  logic signed [SCORE_W-1:0] addend;
  logic signed [ACC_W:0]     sum;
  logic                      ovf;
  logic signed [ACC_W-1:0]   acc_next;
  logic                      sat_next;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] out_score_q;
  logic                    out_sat_q;

  logic out_free, b_done, advance, pop;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign b_done      = b_valid_q && (!b_last_q || out_free);
  assign advance     = !b_valid_q || b_done;
  assign pop_ready_o = !clearing_q && advance;
  assign pop         = pop_valid_i && pop_ready_o;
  assign busy_o      = clearing_q;

  // one memory access a cycle: sweep, table write or lookup
  always_comb begin
    mem_addr  = pop_req_i.addr;
    mem_wdata = '{score: pop_req_i.value, valid: 1'b1};
    mem_we    = pop && (pop_req_i.kind == REQ_WRITE);
    mem_re    = pop && (pop_req_i.kind == REQ_LOOKUP) && pop_req_i.score
                && !pop_req_i.floor_only;
    if (clearing_q) begin
      mem_addr  = clr_q;
      mem_wdata = '0;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (32'(clr_q) == TABLE_ENTRIES - 1) begin
        clearing_d = 1'b0;
      end else begin
        clr_d = clr_q + ADDR_W'(1);
      end
    end
  end

  // saturating add of the window score
  always_comb begin
    addend   = (b_floor_q || !rdata_q.valid) ? floor_score_i : rdata_q.score;
    sum      = (ACC_W+1)'(run_q) + (ACC_W+1)'(addend);
    ovf      = (sum[ACC_W] != sum[ACC_W-1]);
    acc_next = run_q;
    sat_next = sat_q;
    if (b_score_q) begin
      sat_next = sat_q || ovf;
      if (ovf) begin
        acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_next = sum[ACC_W-1:0];
      end
    end
  end

  always_comb begin
    b_valid_d   = advance ? (pop && (pop_req_i.kind == REQ_LOOKUP)) : b_valid_q;
    run_d       = run_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (b_done) begin
      if (b_last_q) begin
        run_d       = '0;
        sat_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        run_d = acc_next;
        sat_d = sat_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      run_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_q       <= clr_d;
      b_valid_q   <= b_valid_d;
      run_q       <= run_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pop) begin
      b_score_q <= pop_req_i.score;
      b_last_q  <= pop_req_i.last;
      b_floor_q <= pop_req_i.floor_only;
    end
    if (b_done && b_last_q) begin
      out_score_q <= acc_next;
      out_sat_q   <= sat_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign text_score_o  = out_score_q;
  assign saturated_o   = out_sat_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop)
    else $error("request taken during clearing sweep");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and write in one cycle");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_done && b_last_q) |=> (run_q == '0) && !sat_q && out_valid_q)
    else $error("accumulator not cleared after result");

  a_stall_holds_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_done) |=> b_valid_q && $stable(run_q)
                               && (!b_score_q || $stable(rdata_q)))
    else $error("stalled lookup lost its data");

endmodule

// ===== sv/quadgram_fitness_scorer.sv =====
`timescale 1ns / 1ps

// quadgram fitness scorer: scores candidate plaintext by summing Q7.8 log-probabilities
// of every four-letter window into a saturating Q23.8 total. the input stream carries
// either table writes (tuser 0: index and Q7.8 score) or text letters (tuser 1, a=0..z=25,
// tlast on the final letter); the final letter of each text yields one result with the
// total and a saturation flag, then the window and total start afresh. entries never
// written score the floor register (reset -25.0), read when the window is scored. after
// reset the table's written marks are cleared by a sweep over all 456976 entries, one entry a
// cycle, during which s_axis_tready stays low; the config port is taken at any time.
// rate is one request a cycle while the result output is not stalled, set by the single
// table port that serves one write or one lookup per cycle; a result's tvalid rises after
// its last letter passes the queue, lookup stage and output register, later if earlier results wait.
// a four-deep queue separates request classification from the table and accumulator

module quadgram_fitness_scorer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // letter, table_index, table_value
  input  logic [0:0]                      s_axis_tuser,   // mode
  input  logic                            s_axis_tlast,   // last_letter
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // text_score
  output logic [0:0]                      m_axis_tuser,   // saturated
  // floor score register
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qfs_pkg::SCORE_W-1:0]     cfg_data_i
);
  import qfs_pkg::*;

  // floor score, Q7.8
  logic signed [SCORE_W-1:0] floor_q, floor_d;

  // front to queue
  logic     push_valid, push_ready;
  qfs_req_t push_req;

  // queue to back
  logic     pop_valid, pop_ready;
  qfs_req_t pop_req;

  logic                    busy;
  logic signed [ACC_W-1:0] text_score;
  logic                    saturated;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    floor_d = floor_q;
    if (cfg_valid_i && cfg_ready_o) begin
      floor_d = $signed(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
    end else begin
      floor_q <= floor_d;
    end
  end

  // classify requests and build window indices
  qfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .busy_i        (busy),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_req_o    (push_req)
  );

  qfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  // table access, accumulation and result register
  qfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_req_i     (pop_req),
    .floor_score_i (floor_q),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .text_score_o  (text_score),
    .saturated_o   (saturated)
  );

  assign m_axis_tdata    = OUT_TDATA_W'(text_score);
  assign m_axis_tuser[0] = saturated;

endmodule
